>>> design/csq_pkg.sv
// Shared types and constants for the cursor sequence store.
`default_nettype none
package csq_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int REQ_W       = 3;
    localparam int DATA_IN_W   = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int VALUE_OUT_W = 32;
    localparam int STATUS_W    = 2;
    localparam int DATA_OUT_W  = 40;

    localparam logic [REQ_W-1:0] REQ_START   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ATTACH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_CURRENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } cmd_t;

endpackage
`default_nettype wire

>>> design/csq_ctrl.sv
// Request sequencer: input capture, execute, and result register load.
`default_nettype none
module csq_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output csq_pkg::cmd_t    cmd
);
    import csq_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_RESP;
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_RESP: cmd.load_out = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted transfer did not start execution");

    a_exec_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> (state_reg == ST_RESP))
        else $error("execute did not move to response");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_RESP && m_tvalid_reg))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

>>> design/csq_datapath.sv
// Entry registers, count and cursor update, and result register.
`default_nettype none
module csq_datapath #(
    parameter int CAPACITY    = csq_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = csq_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire csq_pkg::cmd_t                   cmd,
    input  wire logic [csq_pkg::REQ_W-1:0]       req_type,
    input  wire logic [csq_pkg::DATA_IN_W-1:0]   entry_value,
    output logic      [csq_pkg::DATA_OUT_W-1:0]  result_data
);
    import csq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [REQ_W-1:0]       req_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [DATA_IN_W+VALUE_WIDTH-1:0] value_ext;

    logic [VALUE_WIDTH-1:0] entries_reg  [CAPACITY];
    logic [VALUE_WIDTH-1:0] entries_next [CAPACITY];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       cursor_reg, cursor_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_has_reg;
    logic [VALUE_OUT_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic                   valid;
    logic                   full;
    logic                   do_ins;
    logic                   do_rem;
    logic [CNT_W-1:0]       pos;
    logic [VALUE_WIDTH-1:0] cur_entry;
    logic [VALUE_OUT_W+VALUE_WIDTH-1:0] cur_ext;
    logic [COUNT_OUT_W+CNT_W-1:0]       count_ext;

    assign value_ext = {{VALUE_WIDTH{1'b0}}, entry_value};
    assign valid     = cursor_reg < count_reg;
    assign full      = count_reg >= CNT_W'(CAPACITY);

    always_comb begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        status_next = STAT_DONE;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        pos         = '0;
        case (req_reg)
            REQ_START: cursor_next = '0;
            REQ_ADVANCE: begin
                if (valid) cursor_next = cursor_reg + 1'b1;
                else status_next = STAT_NO_CURRENT;
            end
            REQ_INSERT, REQ_ATTACH: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    if (req_reg == REQ_INSERT) pos = valid ? cursor_reg : '0;
                    else pos = valid ? cursor_reg + 1'b1 : count_reg;
                    do_ins      = 1'b1;
                    count_next  = count_reg + 1'b1;
                    cursor_next = pos;
                end
            end
            REQ_REMOVE: begin
                if (!valid) begin
                    status_next = STAT_NO_CURRENT;
                end else begin
                    do_rem     = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (cursor_reg >= count_reg - 1'b1) cursor_next = count_reg - 1'b1;
                end
            end
            default: begin
                if (!valid) status_next = STAT_NO_CURRENT;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            entries_next[i] = entries_reg[i];
        end
        for (int i = 1; i < CAPACITY; i++) begin
            if (do_ins && CNT_W'(i) > pos) entries_next[i] = entries_reg[i-1];
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (do_ins && CNT_W'(i) == pos) entries_next[i] = value_reg;
        end
        for (int i = 0; i < CAPACITY - 1; i++) begin
            if (do_rem && CNT_W'(i) >= cursor_reg) entries_next[i] = entries_reg[i+1];
        end
    end

    assign cur_entry = valid ? entries_reg[cursor_reg[IDX_W-1:0]] : '0;
    assign cur_ext   = {{VALUE_OUT_W{1'b0}}, cur_entry};
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            cursor_reg <= '0;
        end else if (cmd.exec) begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= req_type;
            value_reg <= value_ext[VALUE_WIDTH-1:0];
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            for (int i = 0; i < CAPACITY; i++) begin
                entries_reg[i] <= entries_next[i];
            end
        end
        if (cmd.load_out) begin
            out_count_reg  <= count_ext[COUNT_OUT_W-1:0];
            out_has_reg    <= valid;
            out_value_reg  <= cur_ext[VALUE_OUT_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign result_data = {out_status_reg, out_value_reg, out_has_reg, out_count_reg};

`ifndef NO_ASSERTIONS
    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= count_reg)
        else $error("cursor beyond entry count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && full && (req_reg == REQ_INSERT || req_reg == REQ_ATTACH))
        |=> $stable(count_reg))
        else $error("full store changed count on insert or attach");
`endif

endmodule
`default_nettype wire

>>> design/cursor_sequence_store.sv
// Top level of the cursor sequence store.
// The sequencer walks capture, execute, then result register load; the load waits while
// an earlier result is still untaken, and no new request is accepted before the load.
// A new request is taken while a finished result still waits in the output register.
// Reset (aresetn low, synchronous) empties the store: count and cursor go to zero.
// Entry contents are not cleared; entries beyond the count are never read.
`default_nettype none
module cursor_sequence_store #(
    parameter int CAPACITY    = csq_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = csq_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [csq_pkg::DATA_IN_W-1:0]   s_tdata,  // entry_value[31:0]
    input  wire logic [csq_pkg::REQ_W-1:0]       s_tuser,  // req_type[2:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // item_count[4:0], has_current[5], current_value[37:6], op_status[39:38]
    output logic      [csq_pkg::DATA_OUT_W-1:0]  m_tdata
);
    import csq_pkg::*;

    cmd_t cmd;

    csq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    csq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .req_type    (s_tuser),
        .entry_value (s_tdata),
        .result_data (m_tdata)
    );

endmodule
`default_nettype wire
